### hw/rtl/frcrc_pkg.sv
`default_nettype none
package frcrc_pkg;

	localparam int unsigned MAX_PAYLOAD_DEF = 4096;
	localparam int unsigned LEN_W           = 13;
	localparam int unsigned IDX_W           = 12;
	localparam logic [LEN_W-1:0] LEN_RESET  = 13'd512;

	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'h0000;
	localparam logic [15:0] CRC_MSB  = 16'h8000;

	localparam logic [23:0] HDR_PREFIX = 24'hDDCCBB;
	localparam logic [7:0]  HDR_LAST   = 8'hAA;

	typedef enum logic [1:0] {
		PHASE_HUNT    = 2'd0,
		PHASE_PAYLOAD = 2'd1,
		PHASE_TRAILER = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_GOOD       = 2'd0,
		ST_FOOTER_BAD = 2'd1,
		ST_CRC_BAD    = 2'd2
	} status_t;

	typedef struct packed {
		logic [7:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		logic             payload_valid;
		logic [7:0]       payload_byte;
		logic [IDX_W-1:0] payload_index;
		logic             frame_end;
		logic [1:0]       frame_status;
	} res_item_t;

	// CRC-16/XMODEM over one byte, MSB first
	function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 16'h0000)
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[14:0], 1'b0};
		end
		return c;
	endfunction

	// footer AA BB CC DD
	function automatic logic [7:0] footer_byte(input logic [1:0] k);
		logic [7:0] f;
		case (k)
			2'd0:    f = 8'hAA;
			2'd1:    f = 8'hBB;
			2'd2:    f = 8'hCC;
			default: f = 8'hDD;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/frcrc_stream_if.sv
`default_nettype none
interface frcrc_stream_if #(
	parameter type T = logic [7:0]
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/frame_receiver_crc16_check.sv
// Frame receiver with CRC-16/XMODEM check.
// rx: one received serial byte per transaction (valid/ready).
// res: exactly one result per received byte, in order: payload bytes with
//   their index, and on the last footer byte frame_end with a status
//   (good, footer mismatch, CRC mismatch). The consumer drops bad frames.
// cfg_wr_en/cfg_wr_data: payload length per frame, written while idle;
//   values above MAX_PAYLOAD act as MAX_PAYLOAD.
// Path: an accepted byte enters the input register, and its result then
//   passes to the result register, which drives res.
// Throughput: one byte per cycle unless res stalls; the header/CRC/footer
//   update is one byte-wide step between the two registers.
// A stalled res holds its result; rx keeps taking bytes until both
//   registers are full, then drops ready.
// Reset: both registers empty, hunting for the header, length 512.
`default_nettype none
module frame_receiver_crc16_check #(
	parameter int unsigned MAX_PAYLOAD = frcrc_pkg::MAX_PAYLOAD_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	frcrc_stream_if.sink                         rx,
	frcrc_stream_if.source                       res,
	input  wire logic                            cfg_wr_en,
	input  wire logic [frcrc_pkg::LEN_W-1:0]     cfg_wr_data
);
	localparam int unsigned LW = ($clog2(MAX_PAYLOAD + 1) > frcrc_pkg::LEN_W) ?
		$clog2(MAX_PAYLOAD + 1) : frcrc_pkg::LEN_W;
	localparam logic [LW-1:0] MAX_LEN = LW'(MAX_PAYLOAD);

	logic [frcrc_pkg::LEN_W-1:0] len_q;
	logic [LW-1:0]               len_ext;
	logic [LW-1:0]               len_eff;
	logic                        v_s1;
	logic [7:0]                  byte_s1;
	logic                        v_s2;
	frcrc_pkg::res_item_t        res_s2;
	frcrc_pkg::res_item_t        res_next;
	logic                        adv;
	frcrc_pkg::rx_item_t         rx_item;

	assign rx_item = rx.data;
	assign len_ext = LW'(len_q);
	assign len_eff = (len_ext > MAX_LEN) ? MAX_LEN : len_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			len_q <= frcrc_pkg::LEN_RESET;
		else if (cfg_wr_en)
			len_q <= cfg_wr_data;
	end

	// advance s1 into s2 when s2 is empty or being drained
	assign adv      = v_s1 && (!v_s2 || res.ready);
	assign rx.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (rx.ready)
				v_s1 <= rx.valid;
			if (adv)
				v_s2 <= 1'b1;
			else if (res.ready)
				v_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready)
			byte_s1 <= rx_item.rx_byte;
		if (adv)
			res_s2 <= res_next;
	end

	frcrc_deframer #(
		.MAX_PAYLOAD (MAX_PAYLOAD),
		.LW          (LW)
	) u_deframer (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (adv),
		.rx_byte (byte_s1),
		.len     (len_eff),
		.res     (res_next)
	);

	assign res.valid = v_s2;
	assign res.data  = res_s2;
endmodule
`default_nettype wire

### hw/rtl/frcrc_deframer.sv
`default_nettype none
module frcrc_deframer #(
	parameter int unsigned MAX_PAYLOAD = frcrc_pkg::MAX_PAYLOAD_DEF,
	parameter int unsigned LW = ($clog2(MAX_PAYLOAD + 1) > frcrc_pkg::LEN_W) ?
		$clog2(MAX_PAYLOAD + 1) : frcrc_pkg::LEN_W
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic [7:0]           rx_byte,
	input  wire logic [LW-1:0]        len,
	output frcrc_pkg::res_item_t      res
);
	localparam int unsigned CW = $clog2(MAX_PAYLOAD);
	localparam int unsigned XW = CW + frcrc_pkg::IDX_W;

	frcrc_pkg::phase_t phase_q, phase_d;
	logic [23:0]   window_q, window_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic [15:0]   crc_q, crc_d;
	logic [7:0]    crc_lo_q, crc_lo_d;
	logic          good_q, good_d;
	logic [XW-1:0] cnt_wide;
	logic [LW-1:0] cnt_next;
	logic [1:0]    foot_k;

	assign cnt_wide = {{frcrc_pkg::IDX_W{1'b0}}, cnt_q};
	assign cnt_next = LW'(cnt_q) + LW'(1);
	assign foot_k   = cnt_q[1:0] - 2'd2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= frcrc_pkg::PHASE_HUNT;
			window_q <= '0;
			cnt_q    <= '0;
			crc_q    <= frcrc_pkg::CRC_INIT;
			crc_lo_q <= '0;
			good_q   <= 1'b1;
		end else if (step) begin
			phase_q  <= phase_d;
			window_q <= window_d;
			cnt_q    <= cnt_d;
			crc_q    <= crc_d;
			crc_lo_q <= crc_lo_d;
			good_q   <= good_d;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		window_d = window_q;
		cnt_d    = cnt_q;
		crc_d    = crc_q;
		crc_lo_d = crc_lo_q;
		good_d   = good_q;
		res      = '0;
		case (phase_q)
			frcrc_pkg::PHASE_PAYLOAD: begin
				res.payload_valid = 1'b1;
				res.payload_byte  = rx_byte;
				res.payload_index = cnt_wide[frcrc_pkg::IDX_W-1:0];
				crc_d = frcrc_pkg::crc16_byte(crc_q, rx_byte);
				if (cnt_next >= len) begin
					phase_d = frcrc_pkg::PHASE_TRAILER;
					cnt_d   = '0;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			frcrc_pkg::PHASE_TRAILER: begin
				if (cnt_q == CW'(0))
					crc_lo_d = rx_byte;
				else if (cnt_q == CW'(1))
					crc_d = crc_q ^ {rx_byte, crc_lo_q};
				else if (rx_byte != frcrc_pkg::footer_byte(foot_k))
					good_d = 1'b0;
				if (cnt_q >= CW'(5)) begin
					res.frame_end = 1'b1;
					// footer mismatch wins over CRC mismatch
					if (!good_d)
						res.frame_status = frcrc_pkg::ST_FOOTER_BAD;
					else if (crc_q != 16'h0000)
						res.frame_status = frcrc_pkg::ST_CRC_BAD;
					else
						res.frame_status = frcrc_pkg::ST_GOOD;
					phase_d  = frcrc_pkg::PHASE_HUNT;
					window_d = '0;
					cnt_d    = '0;
				end else begin
					cnt_d = cnt_q + CW'(1);
				end
			end
			default: begin
				phase_d = frcrc_pkg::PHASE_HUNT;
				if (window_q == frcrc_pkg::HDR_PREFIX && rx_byte == frcrc_pkg::HDR_LAST) begin
					window_d = '0;
					cnt_d    = '0;
					crc_d    = frcrc_pkg::CRC_INIT;
					crc_lo_d = '0;
					good_d   = 1'b1;
					phase_d  = (len == '0) ? frcrc_pkg::PHASE_TRAILER :
						frcrc_pkg::PHASE_PAYLOAD;
				end else begin
					window_d = {window_q[15:0], rx_byte};
				end
			end
		endcase
	end
endmodule
`default_nettype wire

### hw/rtl/frcrc_checker.sv
`default_nettype none
module frcrc_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 res_valid,
	input wire logic                 res_ready,
	input wire frcrc_pkg::res_item_t res_data
);
	a_no_result_in_reset: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

	a_end_not_payload: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res_data.frame_end && res_data.payload_valid))
		else $error("frame end on a payload byte");

	a_status_only_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.frame_end) |-> res_data.frame_status == frcrc_pkg::ST_GOOD)
		else $error("status outside frame end");

	a_idle_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.payload_valid) |->
		(res_data.payload_byte == 8'h00 && res_data.payload_index == '0))
		else $error("payload fields set on non-payload result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> (res_valid && $stable(res_data)))
		else $error("stalled result changed");
endmodule

bind frame_receiver_crc16_check frcrc_checker u_frcrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res.valid),
	.res_ready (res.ready),
	.res_data  (res.data)
);
`default_nettype wire
